>>> design/triangle_midpoint_subdivider_assert.svh
// Assertion macros shared by the subdivider modules.
// Both sample on clk and are disabled while rst_n is low.
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDER_ASSERT_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset
`define TMS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tms assertion failed");
// Condition must never be true at a clock edge out of reset
`define TMS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tms forbidden condition seen");
`else
`define TMS_ASSERT(lbl, prop)
`define TMS_NEVER(lbl, cond)
`endif

`endif

>>> design/tms_pkg.sv
`timescale 1ns / 1ps

package tms_pkg;

    // Field widths
    localparam int INDEX_BITS     = 20;
    localparam int COORD_BITS     = 32;
    localparam int CFG_INDEX_BITS = 1;

    // Largest vertex index / slot; counters saturate here
    localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

    // Triangles held between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BASE_VERTEX   = 1'b0,
        REG_BASE_TRIANGLE = 1'b1
    } cfg_reg_t;

    // Record kinds
    typedef enum logic {
        REC_VERTEX   = 1'b0,
        REC_TRIANGLE = 1'b1
    } rec_kind_t;

    // Record sequence of one triangle
    typedef enum logic [2:0] {
        STEP_AB   = 3'd0,
        STEP_BC   = 3'd1,
        STEP_CA   = 3'd2,
        STEP_OWN  = 3'd3,
        STEP_APP0 = 3'd4,
        STEP_APP1 = 3'd5,
        STEP_APP2 = 3'd6
    } rec_step_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]        index_a;
        logic [INDEX_BITS-1:0]        index_b;
        logic [INDEX_BITS-1:0]        index_c;
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
    } in_item_t;

    typedef struct packed {
        logic                         kind;
        logic [INDEX_BITS-1:0]        slot;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [INDEX_BITS-1:0]        corner_first;
        logic [INDEX_BITS-1:0]        corner_second;
        logic [INDEX_BITS-1:0]        corner_third;
        logic                         overflow;
        logic                         last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } vec3_t;

    // One classified triangle: midpoints and every allocated index
    typedef struct packed {
        logic [INDEX_BITS-1:0] idx_a;
        logic [INDEX_BITS-1:0] idx_b;
        logic [INDEX_BITS-1:0] idx_c;
        vec3_t                 mid_ab;
        vec3_t                 mid_bc;
        vec3_t                 mid_ca;
        logic [INDEX_BITS-1:0] vtx_ab;
        logic [INDEX_BITS-1:0] vtx_bc;
        logic [INDEX_BITS-1:0] vtx_ca;
        logic [INDEX_BITS-1:0] own_slot;
        logic [INDEX_BITS-1:0] app_slot0;
        logic [INDEX_BITS-1:0] app_slot1;
        logic [INDEX_BITS-1:0] app_slot2;
        logic                  overflow;
    } job_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } q_status_t;

endpackage

>>> design/tms_front.sv
`timescale 1ns / 1ps

module tms_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [tms_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [tms_pkg::INDEX_BITS-1:0]          cfg_data,
    input  logic                                    in_valid,
    input  tms_pkg::in_item_t                       in_data,
    input  logic                                    q_full,
    output logic                                    push,
    output tms_pkg::job_t                           job
);

    localparam int IB = tms_pkg::INDEX_BITS;
    localparam int CB = tms_pkg::COORD_BITS;

    // floor((p+q)/2) with one guard bit, no overflow
    function automatic logic signed [CB-1:0] midpoint(
        input logic signed [CB-1:0] p,
        input logic signed [CB-1:0] q
    );
        logic signed [CB:0] s;
        s = {p[CB-1], p} + {q[CB-1], q};
        return s[CB:1];
    endfunction

    // v + k, held at the maximum
    function automatic logic [IB-1:0] sat_add(
        input logic [IB-1:0] v,
        input logic [1:0]    k
    );
        logic [IB:0] s;
        s = {1'b0, v} + {{(IB-1){1'b0}}, k};
        return (s >= {1'b0, tms_pkg::IDX_MAX}) ? tms_pkg::IDX_MAX : s[IB-1:0];
    endfunction

    // true when an allocation at v + k finds the counter at its maximum
    function automatic logic hits_max(
        input logic [IB-1:0] v,
        input logic [1:0]    k
    );
        logic [IB:0] s;
        s = {1'b0, v} + {{(IB-1){1'b0}}, k};
        return s >= {1'b0, tms_pkg::IDX_MAX};
    endfunction

    logic [IB-1:0] base_vertex_reg,   base_vertex_next;
    logic [IB-1:0] base_triangle_reg, base_triangle_next;
    logic [IB-1:0] next_vertex_reg,   next_vertex_next;
    logic [IB-1:0] next_append_reg,   next_append_next;
    logic [IB-1:0] input_slot_reg,    input_slot_next;
    logic          overflow_reg,      overflow_next;
    logic          reload;
    logic          ovf_now;

    assign push = in_valid && !q_full;

    // this triangle's overflow, after all seven allocations
    assign ovf_now = overflow_reg
                   || hits_max(next_vertex_reg, 2'd2)
                   || hits_max(input_slot_reg, 2'd0)
                   || hits_max(next_append_reg, 2'd2);

    // classify: midpoints and allocations
    always_comb
    begin
        job.idx_a     = in_data.index_a;
        job.idx_b     = in_data.index_b;
        job.idx_c     = in_data.index_c;
        job.mid_ab.x  = midpoint(in_data.a_x, in_data.b_x);
        job.mid_ab.y  = midpoint(in_data.a_y, in_data.b_y);
        job.mid_ab.z  = midpoint(in_data.a_z, in_data.b_z);
        job.mid_bc.x  = midpoint(in_data.b_x, in_data.c_x);
        job.mid_bc.y  = midpoint(in_data.b_y, in_data.c_y);
        job.mid_bc.z  = midpoint(in_data.b_z, in_data.c_z);
        job.mid_ca.x  = midpoint(in_data.c_x, in_data.a_x);
        job.mid_ca.y  = midpoint(in_data.c_y, in_data.a_y);
        job.mid_ca.z  = midpoint(in_data.c_z, in_data.a_z);
        job.vtx_ab    = sat_add(next_vertex_reg, 2'd0);
        job.vtx_bc    = sat_add(next_vertex_reg, 2'd1);
        job.vtx_ca    = sat_add(next_vertex_reg, 2'd2);
        job.own_slot  = input_slot_reg;
        job.app_slot0 = sat_add(next_append_reg, 2'd0);
        job.app_slot1 = sat_add(next_append_reg, 2'd1);
        job.app_slot2 = sat_add(next_append_reg, 2'd2);
        job.overflow  = ovf_now;
    end

    // register writes and counter update
    always_comb
    begin
        base_vertex_next   = base_vertex_reg;
        base_triangle_next = base_triangle_reg;
        reload             = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                tms_pkg::REG_BASE_VERTEX:
                begin
                    base_vertex_next = cfg_data;
                    reload           = 1'b1;
                end
                tms_pkg::REG_BASE_TRIANGLE:
                begin
                    base_triangle_next = cfg_data;
                    reload             = 1'b1;
                end
                default:
                begin
                    reload = 1'b0;
                end
            endcase
        end

        next_vertex_next = next_vertex_reg;
        next_append_next = next_append_reg;
        input_slot_next  = input_slot_reg;
        overflow_next    = overflow_reg;
        if (reload)
        begin
            next_vertex_next = base_vertex_next;
            next_append_next = base_triangle_next;
            input_slot_next  = '0;
            overflow_next    = 1'b0;
        end
        else if (push)
        begin
            next_vertex_next = sat_add(next_vertex_reg, 2'd3);
            next_append_next = sat_add(next_append_reg, 2'd3);
            input_slot_next  = sat_add(input_slot_reg, 2'd1);
            overflow_next    = ovf_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_vertex_reg   <= '0;
            base_triangle_reg <= '0;
            next_vertex_reg   <= '0;
            next_append_reg   <= '0;
            input_slot_reg    <= '0;
            overflow_reg      <= 1'b0;
        end
        else
        begin
            base_vertex_reg   <= base_vertex_next;
            base_triangle_reg <= base_triangle_next;
            next_vertex_reg   <= next_vertex_next;
            next_append_reg   <= next_append_next;
            input_slot_reg    <= input_slot_next;
            overflow_reg      <= overflow_next;
        end
    end

endmodule

>>> design/tms_queue.sv
`timescale 1ns / 1ps

`include "triangle_midpoint_subdivider_assert.svh"

module tms_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  tms_pkg::q_ctrl_t    ctrl,
    input  tms_pkg::job_t       wr_job,
    output tms_pkg::q_status_t  status,
    output tms_pkg::job_t       head_job
);

    localparam int DEPTH    = tms_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    tms_pkg::job_t        slots_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg,  count_next;

    assign status.full       = (count_reg == CNT_BITS'(DEPTH));
    assign status.head_valid = (count_reg != '0);
    assign head_job          = slots_reg[rd_ptr_reg];

    // pointers wrap naturally since the depth is a power of two
    always_comb
    begin
        wr_ptr_next = ctrl.push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = ctrl.pop  ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        case ({ctrl.push, ctrl.pop})
            2'b10:   count_next = count_reg + CNT_BITS'(1);
            2'b01:   count_next = count_reg - CNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

    `TMS_NEVER(a_q_overfill, count_reg > CNT_BITS'(DEPTH))
    `TMS_NEVER(a_q_push_full, ctrl.push && status.full)
    `TMS_NEVER(a_q_pop_empty, ctrl.pop && !status.head_valid)

endmodule

>>> design/tms_back.sv
`timescale 1ns / 1ps

`include "triangle_midpoint_subdivider_assert.svh"

module tms_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  tms_pkg::job_t       job,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output tms_pkg::out_item_t  out_data
);

    tms_pkg::rec_step_t  step_reg, step_next;
    tms_pkg::out_item_t  rec;
    tms_pkg::out_item_t  out_data_reg;
    logic                out_valid_reg, out_valid_next;
    logic                load;

    // output register takes a record when empty or being drained
    assign load      = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // record selection and sequence
    always_comb
    begin
        rec               = '0;
        rec.overflow      = job.overflow;
        step_next         = step_reg;
        q_pop             = 1'b0;
        out_valid_next    = load || (out_valid_reg && out_stall);
        case (step_reg)
            tms_pkg::STEP_AB:
            begin
                rec.kind  = tms_pkg::REC_VERTEX;
                rec.slot  = job.vtx_ab;
                rec.pos_x = job.mid_ab.x;
                rec.pos_y = job.mid_ab.y;
                rec.pos_z = job.mid_ab.z;
                step_next = load ? tms_pkg::STEP_BC : step_reg;
            end
            tms_pkg::STEP_BC:
            begin
                rec.kind  = tms_pkg::REC_VERTEX;
                rec.slot  = job.vtx_bc;
                rec.pos_x = job.mid_bc.x;
                rec.pos_y = job.mid_bc.y;
                rec.pos_z = job.mid_bc.z;
                step_next = load ? tms_pkg::STEP_CA : step_reg;
            end
            tms_pkg::STEP_CA:
            begin
                rec.kind  = tms_pkg::REC_VERTEX;
                rec.slot  = job.vtx_ca;
                rec.pos_x = job.mid_ca.x;
                rec.pos_y = job.mid_ca.y;
                rec.pos_z = job.mid_ca.z;
                step_next = load ? tms_pkg::STEP_OWN : step_reg;
            end
            tms_pkg::STEP_OWN:
            begin
                rec.kind          = tms_pkg::REC_TRIANGLE;
                rec.slot          = job.own_slot;
                rec.corner_first  = job.idx_a;
                rec.corner_second = job.vtx_ab;
                rec.corner_third  = job.vtx_ca;
                step_next         = load ? tms_pkg::STEP_APP0 : step_reg;
            end
            tms_pkg::STEP_APP0:
            begin
                rec.kind          = tms_pkg::REC_TRIANGLE;
                rec.slot          = job.app_slot0;
                rec.corner_first  = job.vtx_ab;
                rec.corner_second = job.idx_b;
                rec.corner_third  = job.vtx_bc;
                step_next         = load ? tms_pkg::STEP_APP1 : step_reg;
            end
            tms_pkg::STEP_APP1:
            begin
                rec.kind          = tms_pkg::REC_TRIANGLE;
                rec.slot          = job.app_slot1;
                rec.corner_first  = job.vtx_ca;
                rec.corner_second = job.vtx_bc;
                rec.corner_third  = job.idx_c;
                step_next         = load ? tms_pkg::STEP_APP2 : step_reg;
            end
            tms_pkg::STEP_APP2:
            begin
                rec.kind          = tms_pkg::REC_TRIANGLE;
                rec.slot          = job.app_slot2;
                rec.corner_first  = job.vtx_ca;
                rec.corner_second = job.vtx_ab;
                rec.corner_third  = job.vtx_bc;
                rec.last          = 1'b1;
                q_pop             = load;
                step_next         = load ? tms_pkg::STEP_AB : step_reg;
            end
            default:
            begin
                step_next = tms_pkg::STEP_AB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= tms_pkg::STEP_AB;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= rec;
        end
    end

    `TMS_ASSERT(a_b_head_held, (step_reg != tms_pkg::STEP_AB) |-> q_valid)
    `TMS_ASSERT(a_b_vertex_not_last, (out_valid_reg && (out_data_reg.kind == tms_pkg::REC_VERTEX)) |-> !out_data_reg.last)
    `TMS_ASSERT(a_b_last_ends_seq, (out_valid_reg && out_data_reg.last) |-> (step_reg == tms_pkg::STEP_AB))

endmodule

>>> design/triangle_midpoint_subdivider.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat                   Handshake
// cfg       in         register write         cfg_we (no wait)
// in        in         one triangle           in_valid / in_stall
// out       out        one vertex/tri record  out_valid / out_stall
//
// Each triangle yields seven output beats, so the single result port limits
// how fast triangles can be taken in a sustained stream.
// First record passes through the queue and then the output register before it is visible.
// A two-entry triangle queue sits between intake and record emission;
// in_stall rises only when it is full. Reset empties it and zeros counters.
// out_stall holds the output register; intake keeps going until the queue fills.

module triangle_midpoint_subdivider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tms_pkg::INDEX_BITS-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tms_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tms_pkg::out_item_t                  out_data
);

    tms_pkg::q_ctrl_t    q_ctrl;
    tms_pkg::q_status_t  q_status;
    tms_pkg::job_t       front_job;
    tms_pkg::job_t       head_job;
    logic                push;
    logic                pop;

    assign in_stall    = q_status.full;
    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    // intake, midpoint math and index allocation
    tms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .q_full    (q_status.full),
        .push      (push),
        .job       (front_job)
    );

    // classified triangles waiting for emission
    tms_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (q_ctrl),
        .wr_job   (front_job),
        .status   (q_status),
        .head_job (head_job)
    );

    // seven-record sequencer and output register
    tms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_status.head_valid),
        .job       (head_job),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> test/tb_triangle_midpoint_subdivider.sv
`timescale 1ns / 1ps

module tb_triangle_midpoint_subdivider;

    localparam int IB = tms_pkg::INDEX_BITS;
    localparam int CB = tms_pkg::COORD_BITS;
    localparam logic signed [CB-1:0] CMAX = 32'sh7FFF_FFFF;
    localparam logic signed [CB-1:0] CMIN = 32'sh8000_0000;
    localparam int RECS_PER_TRI  = 7;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 150;
    localparam int WATCHDOG      = 3000;
    localparam int MAX_REPORTS   = 10;

    // Directed plan: either a register write or one triangle
    typedef enum logic {
        ROW_TRI,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t           op;
        tms_pkg::cfg_reg_t   reg_sel;
        logic [IB-1:0]       reg_val;
        tms_pkg::in_item_t   tri_in;
        logic                typed;
        tms_pkg::out_item_t  typed_ab;
    } row_t;

    // Allocation counters of the local model
    typedef enum int {
        CTR_VERTEX = 0,
        CTR_OWN    = 1,
        CTR_APPEND = 2
    } ctr_sel_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    tms_pkg::cfg_reg_t   cfg_index;
    logic [IB-1:0]       cfg_data;
    logic                in_valid;
    logic                in_stall;
    tms_pkg::in_item_t   in_data;
    logic                out_valid;
    logic                out_stall;
    tms_pkg::out_item_t  out_data;

    // Model state
    logic [IB-1:0] base_vertex;
    logic [IB-1:0] base_triangle;
    logic [IB-1:0] ctr [3];
    logic          ovf_sticky;

    tms_pkg::out_item_t pending_records [$];
    row_t               plan [$];

    int  mismatches;
    int  reports;
    int  triangles_sent;
    int  records_checked;
    int  ovf_records;
    int  in_stall_beats;
    int  quiet_cycles;
    int  in_idle_pct;
    int  out_idle_pct;
    bit  hold_req;
    tms_pkg::out_item_t expd;

    triangle_midpoint_subdivider dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ---------------- model ----------------

    // floor((p+q)/2) without losing the carry
    function automatic logic signed [CB-1:0] half_sum(
        logic signed [CB-1:0] p, logic signed [CB-1:0] q);
        logic [CB:0] s;
        s = {p[CB-1], p} + {q[CB-1], q};
        return s[CB:1];
    endfunction

    function automatic tms_pkg::vec3_t midpoint(tms_pkg::vec3_t p, tms_pkg::vec3_t q);
        tms_pkg::vec3_t m;
        m.x = half_sum(p.x, q.x);
        m.y = half_sum(p.y, q.y);
        m.z = half_sum(p.z, q.z);
        return m;
    endfunction

    function automatic tms_pkg::vec3_t v3(logic signed [CB-1:0] x,
                                          logic signed [CB-1:0] y,
                                          logic signed [CB-1:0] z);
        tms_pkg::vec3_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    // Hand out a counter value; saturate and flag at the top
    function automatic logic [IB-1:0] grab(ctr_sel_t s);
        logic [IB-1:0] v;
        v = ctr[s];
        if (v == tms_pkg::IDX_MAX)
            ovf_sticky = 1'b1;
        else
            ctr[s] = v + 1'b1;
        return v;
    endfunction

    function automatic tms_pkg::out_item_t vertex_record(logic [IB-1:0] idx,
                                                         tms_pkg::vec3_t p, logic ovf);
        tms_pkg::out_item_t r;
        r = '0;
        r.kind     = tms_pkg::REC_VERTEX;
        r.slot     = idx;
        r.pos_x    = p.x;
        r.pos_y    = p.y;
        r.pos_z    = p.z;
        r.overflow = ovf;
        return r;
    endfunction

    function automatic tms_pkg::out_item_t triangle_record(logic [IB-1:0] s,
        logic [IB-1:0] c0, logic [IB-1:0] c1,
        logic [IB-1:0] c2, logic ovf, logic fin);
        tms_pkg::out_item_t r;
        r = '0;
        r.kind          = tms_pkg::REC_TRIANGLE;
        r.slot          = s;
        r.corner_first  = c0;
        r.corner_second = c1;
        r.corner_third  = c2;
        r.overflow      = ovf;
        r.last          = fin;
        return r;
    endfunction

    function automatic void reload_counters();
        ctr[CTR_VERTEX] = base_vertex;
        ctr[CTR_OWN]    = '0;
        ctr[CTR_APPEND] = base_triangle;
        ovf_sticky      = 1'b0;
    endfunction

    // Append one expected record at the tail of the scoreboard
    function automatic void expect_record(tms_pkg::out_item_t r);
        pending_records.insert(pending_records.size(), r);
    endfunction

    // Seven records of one subdivided triangle, queued in emission order
    function automatic void subdivide_triangle(tms_pkg::in_item_t t);
        tms_pkg::vec3_t a, b, c, ab, bc, ca;
        logic [IB-1:0] v_ab, v_bc, v_ca, own, s0, s1, s2;
        a  = v3(t.a_x, t.a_y, t.a_z);
        b  = v3(t.b_x, t.b_y, t.b_z);
        c  = v3(t.c_x, t.c_y, t.c_z);
        ab = midpoint(a, b);
        bc = midpoint(b, c);
        ca = midpoint(c, a);
        v_ab = grab(CTR_VERTEX);
        v_bc = grab(CTR_VERTEX);
        v_ca = grab(CTR_VERTEX);
        own  = grab(CTR_OWN);
        s0   = grab(CTR_APPEND);
        s1   = grab(CTR_APPEND);
        s2   = grab(CTR_APPEND);
        expect_record(vertex_record(v_ab, ab, ovf_sticky));
        expect_record(vertex_record(v_bc, bc, ovf_sticky));
        expect_record(vertex_record(v_ca, ca, ovf_sticky));
        expect_record(triangle_record(own, t.index_a, v_ab, v_ca, ovf_sticky, 1'b0));
        expect_record(triangle_record(s0, v_ab, t.index_b, v_bc, ovf_sticky, 1'b0));
        expect_record(triangle_record(s1, v_ca, v_bc, t.index_c, ovf_sticky, 1'b0));
        expect_record(triangle_record(s2, v_ca, v_ab, v_bc, ovf_sticky, 1'b1));
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic tms_pkg::in_item_t mk_tri(logic [IB-1:0] ia,
        logic [IB-1:0] ib, logic [IB-1:0] ic,
        tms_pkg::vec3_t a, tms_pkg::vec3_t b, tms_pkg::vec3_t c);
        tms_pkg::in_item_t t;
        t.index_a = ia;
        t.index_b = ib;
        t.index_c = ic;
        t.a_x = a.x;
        t.a_y = a.y;
        t.a_z = a.z;
        t.b_x = b.x;
        t.b_y = b.y;
        t.b_z = b.z;
        t.c_x = c.x;
        t.c_y = c.y;
        t.c_z = c.z;
        return t;
    endfunction

    // Append one row at the end of the directed plan
    function automatic void append_row(row_t r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic void add_tri(tms_pkg::in_item_t t, logic typed,
                                    tms_pkg::out_item_t ab_rec);
        row_t r;
        r.op       = ROW_TRI;
        r.reg_sel  = tms_pkg::REG_BASE_VERTEX;
        r.reg_val  = '0;
        r.tri_in   = t;
        r.typed    = typed;
        r.typed_ab = ab_rec;
        append_row(r);
    endfunction

    function automatic void add_cfg(tms_pkg::cfg_reg_t sel, logic [IB-1:0] val);
        row_t r;
        r.op       = ROW_CFG;
        r.reg_sel  = sel;
        r.reg_val  = val;
        r.tri_in   = '0;
        r.typed    = 1'b0;
        r.typed_ab = '0;
        append_row(r);
    endfunction

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(9))
            0: return CMAX;
            1: return CMIN;
            2: return '0;
            3: return -1;
            4, 5: return $signed($urandom_range(511)) - 256;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IB-1:0] rand_index();
        case ($urandom_range(7))
            0: return '0;
            1: return tms_pkg::IDX_MAX;
            default: return $urandom_range(tms_pkg::IDX_MAX);
        endcase
    endfunction

    function automatic tms_pkg::in_item_t rand_tri();
        return mk_tri(rand_index(), rand_index(), rand_index(),
                      v3(rand_coord(), rand_coord(), rand_coord()),
                      v3(rand_coord(), rand_coord(), rand_coord()),
                      v3(rand_coord(), rand_coord(), rand_coord()));
    endfunction

    // Offer one triangle beat; predict once it is taken
    task automatic send_tri(tms_pkg::in_item_t t, logic typed, tms_pkg::out_item_t ab_rec);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        subdivide_triangle(t);
        if (typed)
            pending_records[pending_records.size() - RECS_PER_TRI] = ab_rec;
        triangles_sent++;
    endtask

    // Let all outstanding records drain, then settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(tms_pkg::cfg_reg_t sel, logic [IB-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (sel == tms_pkg::REG_BASE_VERTEX)
            base_vertex = val;
        else
            base_triangle = val;
        reload_counters();
    endtask

    task automatic run_phase(logic [IB-1:0] vtx, logic [IB-1:0] tri_base,
                             int n, int in_pct, int out_pct, bit hold);
        write_reg(tms_pkg::REG_BASE_TRIANGLE, tri_base);
        write_reg(tms_pkg::REG_BASE_VERTEX, vtx);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        hold_req     = hold;
        repeat (n) send_tri(rand_tri(), 1'b0, '0);
    endtask

    // ---------------- checking ----------------

    task automatic note_bad(string what, logic [63:0] e, logic [63:0] g);
        mismatches++;
        if (reports < MAX_REPORTS)
        begin
            reports++;
            $display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, e, g);
        end
    endtask

    // Output monitor: compare every accepted record beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                in_stall_beats++;
            if (out_valid && !out_stall)
            begin
                records_checked++;
                if (out_data.overflow)
                    ovf_records++;
                if (pending_records.size() == 0)
                    note_bad("record with none pending", '0, out_data);
                else
                begin
                    expd = pending_records.pop_front();
                    if (out_data.kind !== expd.kind)
                        note_bad("kind", expd.kind, out_data.kind);
                    if (out_data.slot !== expd.slot)
                        note_bad("slot", expd.slot, out_data.slot);
                    if (out_data.pos_x !== expd.pos_x)
                        note_bad("pos_x", expd.pos_x, out_data.pos_x);
                    if (out_data.pos_y !== expd.pos_y)
                        note_bad("pos_y", expd.pos_y, out_data.pos_y);
                    if (out_data.pos_z !== expd.pos_z)
                        note_bad("pos_z", expd.pos_z, out_data.pos_z);
                    if (out_data.corner_first !== expd.corner_first)
                        note_bad("corner_first", expd.corner_first, out_data.corner_first);
                    if (out_data.corner_second !== expd.corner_second)
                        note_bad("corner_second", expd.corner_second,
                                 out_data.corner_second);
                    if (out_data.corner_third !== expd.corner_third)
                        note_bad("corner_third", expd.corner_third, out_data.corner_third);
                    if (out_data.overflow !== expd.overflow)
                        note_bad("overflow", expd.overflow, out_data.overflow);
                    if (out_data.last !== expd.last)
                        note_bad("last", expd.last, out_data.last);
                end
            end
        end
    end

    // Watchdog: cycles in a row with no beat on any port
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("watchdog: no beat for %0d cycles, %0d records pending",
                         quiet_cycles, pending_records.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= tms_pkg::REG_BASE_VERTEX;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        mismatches   = 0;
        reports      = 0;
        triangles_sent  = 0;
        records_checked = 0;
        ovf_records     = 0;
        in_stall_beats  = 0;
        quiet_cycles    = 0;
        in_idle_pct  = 12;
        out_idle_pct = 12;
        hold_req     = 1'b0;
        base_vertex   = '0;
        base_triangle = '0;
        reload_counters();

        // Directed plan; the first rows run on reset values
        add_tri(mk_tri('0, '0, '0, v3(0, 0, 0), v3(0, 0, 0), v3(0, 0, 0)),
                1'b1, vertex_record(20'd0, v3(0, 0, 0), 1'b0));
        add_tri(mk_tri(tms_pkg::IDX_MAX, tms_pkg::IDX_MAX, tms_pkg::IDX_MAX,
                       v3(CMAX, CMAX, CMAX), v3(CMAX, CMAX, CMAX), v3(CMAX, CMAX, CMAX)),
                1'b1, vertex_record(20'd3, v3(CMAX, CMAX, CMAX), 1'b0));
        add_tri(mk_tri('0, tms_pkg::IDX_MAX, '0, v3(CMIN, CMIN, CMIN),
                       v3(CMIN, CMIN, CMIN), v3(CMIN, CMIN, CMIN)),
                1'b1, vertex_record(20'd6, v3(CMIN, CMIN, CMIN), 1'b0));
        // opposite extremes: sum is -1, floor gives -1
        add_tri(mk_tri(20'd1, 20'd2, 20'd3, v3(CMAX, CMAX, CMAX),
                       v3(CMIN, CMIN, CMIN), v3(0, 0, 0)),
                1'b1, vertex_record(20'd9, v3(-1, -1, -1), 1'b0));
        add_tri(mk_tri(20'd5, 20'd6, 20'd7, v3(1, -1, 3), v3(0, -2, -4),
                       v3(CMIN, CMAX, -1)), 1'b0, '0);
        add_tri(mk_tri(20'h55555, 20'hAAAAA, 20'h0F0F0, v3(32'h0001_0000, -98304, 7),
                       v3(-5, 32'h7FFF_0000, CMIN), v3(32'h1234_5678, 0, CMAX)),
                1'b0, '0);
        // near the top of both counters: saturation mid-triangle
        add_cfg(tms_pkg::REG_BASE_VERTEX, tms_pkg::IDX_MAX - 20'd4);
        add_cfg(tms_pkg::REG_BASE_TRIANGLE, tms_pkg::IDX_MAX - 20'd2);
        add_tri(mk_tri(20'd10, 20'd11, 20'd12, v3(100, -100, 0), v3(-7, 9, 1),
                       v3(CMAX, CMIN, 2)), 1'b0, '0);
        add_tri(mk_tri(tms_pkg::IDX_MAX, 20'd0, 20'd77, v3(3, 3, 3), v3(-3, -3, -3),
                       v3(1, 2, 3)), 1'b0, '0);
        // vertex counter starts saturated
        add_cfg(tms_pkg::REG_BASE_VERTEX, tms_pkg::IDX_MAX);
        add_tri(mk_tri(20'd1, 20'd2, 20'd3, v3(2, 4, 6), v3(0, 0, 0), v3(0, 0, 0)),
                1'b1, vertex_record(tms_pkg::IDX_MAX, v3(1, 2, 3), 1'b1));
        // reload clears the flag; odd negative sum rounds down
        add_cfg(tms_pkg::REG_BASE_VERTEX, '0);
        add_cfg(tms_pkg::REG_BASE_TRIANGLE, '0);
        add_tri(mk_tri(20'd4, 20'd5, 20'd6, v3(-3, -3, -3), v3(0, 0, 0), v3(9, 9, 9)),
                1'b1, vertex_record(20'd0, v3(-2, -2, -2), 1'b0));
        add_tri(rand_tri(), 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].op == ROW_CFG)
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            else
                send_tri(plan[i].tri_in, plan[i].typed, plan[i].typed_ab);
        end

        // Random phases across register settings
        run_phase($urandom_range(tms_pkg::IDX_MAX), $urandom_range(tms_pkg::IDX_MAX),
                  120, 12, 12, 1'b0);
        run_phase(tms_pkg::IDX_MAX - 20'd100, tms_pkg::IDX_MAX - 20'd30,
                  60, 12, 12, 1'b0);
        run_phase('0, '0, 120, 0, 0, 1'b0);
        run_phase($urandom_range(tms_pkg::IDX_MAX), $urandom_range(tms_pkg::IDX_MAX),
                  120, 0, 12, 1'b1);
        run_phase(tms_pkg::IDX_MAX, tms_pkg::IDX_MAX, 60, 12, 12, 1'b0);

        wait_idle();
        repeat (10) @(posedge clk);

        $display("%0d triangles in, %0d records checked, %0d with overflow set",
                 triangles_sent, records_checked, ovf_records);
        $display("input stalled on %0d beats; %0d field mismatches",
                 in_stall_beats, mismatches);
        if (mismatches == 0 && pending_records.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/tms_pkg.sv
design/tms_front.sv
design/tms_queue.sv
design/tms_back.sv
design/triangle_midpoint_subdivider.sv
test/tb_triangle_midpoint_subdivider.sv
